/* design/touch_gesture_classifier_top_defines.svh */
// Assertion macros used by the touch gesture classifier checker.
`ifndef TOUCH_GESTURE_CLASSIFIER_TOP_DEFINES_SVH
`define TOUCH_GESTURE_CLASSIFIER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TGC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TGC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/tgc_pkg.sv */
// Shared types, constants and helper functions of the touch gesture classifier.
package tgc_pkg;

  localparam int COORD_BITS = 12;
  localparam int SWIPE_W    = 12;
  localparam int TIME_W     = 32;
  localparam int MSEC_W     = 16;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 4;
  localparam int CMP_W      = (COORD_BITS > SWIPE_W) ? COORD_BITS : SWIPE_W;

  localparam logic [MSEC_W-1:0]  LONG_PRESS_RST = MSEC_W'(600);
  localparam logic [SWIPE_W-1:0] SWIPE_MIN_RST  = SWIPE_W'(60);
  localparam logic [SWIPE_W-1:0] SWIPE_CROSS_RST = SWIPE_W'(60);
  localparam logic [MSEC_W-1:0]  DTAP_WIN_RST   = MSEC_W'(300);

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {
    REG_LONG_PRESS  = 2'd0,
    REG_SWIPE_MIN   = 2'd1,
    REG_SWIPE_CROSS = 2'd2,
    REG_DTAP_WIN    = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_TAP   = 3'd1,
    EV_DTAP  = 3'd2,
    EV_LONG  = 3'd3,
    EV_LEFT  = 3'd4,
    EV_RIGHT = 3'd5,
    EV_UP    = 3'd6,
    EV_DOWN  = 3'd7
  } ev_t;

  typedef struct packed {
    logic [MSEC_W-1:0]  long_press_time;
    logic [SWIPE_W-1:0] swipe_min_distance;
    logic [SWIPE_W-1:0] swipe_max_cross;
    logic [MSEC_W-1:0]  double_tap_window;
  } cfg_t;

  typedef struct packed {
    logic              touching;
    coord_t            pos_x;
    coord_t            pos_y;
    logic [TIME_W-1:0] time_ms;
  } sample_t;

  function automatic coord_t abs_diff(input coord_t a, input coord_t b);
    return (a >= b) ? coord_t'(a - b) : coord_t'(b - a);
  endfunction

  function automatic logic [CMP_W-1:0] wide_c(input coord_t d);
    return CMP_W'(d);
  endfunction

  function automatic logic [CMP_W-1:0] wide_l(input logic [SWIPE_W-1:0] l);
    return CMP_W'(l);
  endfunction

endpackage

/* design/tgc_cfg.sv */
// APB register file holding the classifier thresholds.
module tgc_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tgc_pkg::ADDR_W-1:0]  paddr,
  input  logic [tgc_pkg::DATA_W-1:0]  pwdata,
  output logic [tgc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output tgc_pkg::cfg_t               cfg
);

  tgc_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = tgc_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_time    <= tgc_pkg::LONG_PRESS_RST;
      cfg.swipe_min_distance <= tgc_pkg::SWIPE_MIN_RST;
      cfg.swipe_max_cross    <= tgc_pkg::SWIPE_CROSS_RST;
      cfg.double_tap_window  <= tgc_pkg::DTAP_WIN_RST;
    end else if (wr_en) begin
      unique case (idx)
        tgc_pkg::REG_LONG_PRESS:  cfg.long_press_time    <= pwdata[tgc_pkg::MSEC_W-1:0];
        tgc_pkg::REG_SWIPE_MIN:   cfg.swipe_min_distance <= pwdata[tgc_pkg::SWIPE_W-1:0];
        tgc_pkg::REG_SWIPE_CROSS: cfg.swipe_max_cross    <= pwdata[tgc_pkg::SWIPE_W-1:0];
        tgc_pkg::REG_DTAP_WIN:    cfg.double_tap_window  <= pwdata[tgc_pkg::MSEC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tgc_pkg::REG_LONG_PRESS:  prdata = tgc_pkg::DATA_W'(cfg.long_press_time);
      tgc_pkg::REG_SWIPE_MIN:   prdata = tgc_pkg::DATA_W'(cfg.swipe_min_distance);
      tgc_pkg::REG_SWIPE_CROSS: prdata = tgc_pkg::DATA_W'(cfg.swipe_max_cross);
      tgc_pkg::REG_DTAP_WIN:    prdata = tgc_pkg::DATA_W'(cfg.double_tap_window);
      default:                  prdata = '0;
    endcase
  end

endmodule

/* design/tgc_core.sv */
// Gesture state and single-pass classification of one touch sample.
module tgc_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  tgc_pkg::sample_t smp,
  input  tgc_pkg::cfg_t    cfg,
  output tgc_pkg::ev_t     ev
);

  typedef struct packed {
    logic                       is_pressing;
    logic                       long_done;
    logic [tgc_pkg::TIME_W-1:0] start_time;
    tgc_pkg::coord_t            start_x;
    tgc_pkg::coord_t            start_y;
    tgc_pkg::coord_t            recent_x;
    tgc_pkg::coord_t            recent_y;
    logic                       tap_waiting;
    logic [tgc_pkg::TIME_W-1:0] tap_time;
    tgc_pkg::coord_t            tap_x;
    tgc_pkg::coord_t            tap_y;
  } gest_t;

  gest_t st;
  gest_t st_next;

  logic [tgc_pkg::CMP_W-1:0]  min_d;
  logic [tgc_pkg::CMP_W-1:0]  max_c;
  // pressed path
  tgc_pkg::coord_t            sx_eff;
  tgc_pkg::coord_t            sy_eff;
  logic [tgc_pkg::TIME_W-1:0] st_eff;
  logic [tgc_pkg::CMP_W-1:0]  dx_now;
  logic [tgc_pkg::CMP_W-1:0]  dy_now;
  logic [tgc_pkg::TIME_W-1:0] held;
  logic                       long_fire;
  // release path
  logic [tgc_pkg::CMP_W-1:0]  ax;
  logic [tgc_pkg::CMP_W-1:0]  ay;
  logic [tgc_pkg::CMP_W-1:0]  tdx;
  logic [tgc_pkg::CMP_W-1:0]  tdy;
  logic [tgc_pkg::TIME_W-1:0] since_tap;
  logic                       armed;
  logic                       swipe_h;
  logic                       swipe_v;
  logic                       is_tap;
  logic                       is_dtap;

  assign min_d = tgc_pkg::wide_l(cfg.swipe_min_distance);
  assign max_c = tgc_pkg::wide_l(cfg.swipe_max_cross);

  // a sample that opens a gesture measures against itself
  assign sx_eff = st.is_pressing ? st.start_x : smp.pos_x;
  assign sy_eff = st.is_pressing ? st.start_y : smp.pos_y;
  assign st_eff = st.is_pressing ? st.start_time : smp.time_ms;
  assign dx_now = tgc_pkg::wide_c(tgc_pkg::abs_diff(smp.pos_x, sx_eff));
  assign dy_now = tgc_pkg::wide_c(tgc_pkg::abs_diff(smp.pos_y, sy_eff));
  assign held   = smp.time_ms - st_eff;

  assign long_fire = !(st.is_pressing && st.long_done) && (dx_now < min_d) &&
                     (dy_now < min_d) &&
                     (held >= tgc_pkg::TIME_W'(cfg.long_press_time));

  assign ax        = tgc_pkg::wide_c(tgc_pkg::abs_diff(st.recent_x, st.start_x));
  assign ay        = tgc_pkg::wide_c(tgc_pkg::abs_diff(st.recent_y, st.start_y));
  assign tdx       = tgc_pkg::wide_c(tgc_pkg::abs_diff(st.recent_x, st.tap_x));
  assign tdy       = tgc_pkg::wide_c(tgc_pkg::abs_diff(st.recent_y, st.tap_y));
  assign since_tap = smp.time_ms - st.tap_time;

  assign armed   = st.is_pressing && !st.long_done;
  assign swipe_h = (ax >= min_d) && (ay <= max_c);
  assign swipe_v = (ay >= min_d) && (ax <= max_c);
  assign is_tap  = armed && !swipe_h && !swipe_v && (ax < min_d) && (ay < min_d);
  assign is_dtap = is_tap && st.tap_waiting &&
                   (since_tap < tgc_pkg::TIME_W'(cfg.double_tap_window)) &&
                   (tdx <= min_d) && (tdy <= min_d);

  always_comb begin
    ev = tgc_pkg::EV_NONE;
    if (smp.touching) begin
      if (long_fire) ev = tgc_pkg::EV_LONG;
    end else if (armed) begin
      if (swipe_h) begin
        ev = (st.recent_x > st.start_x) ? tgc_pkg::EV_RIGHT : tgc_pkg::EV_LEFT;
      end else if (swipe_v) begin
        ev = (st.recent_y > st.start_y) ? tgc_pkg::EV_DOWN : tgc_pkg::EV_UP;
      end else if (is_dtap) begin
        ev = tgc_pkg::EV_DTAP;
      end else if (is_tap) begin
        ev = tgc_pkg::EV_TAP;
      end
    end
  end

  always_comb begin
    st_next = st;
    if (smp.touching) begin
      if (!st.is_pressing) begin
        st_next.is_pressing = 1'b1;
        st_next.long_done   = 1'b0;
        st_next.start_x     = smp.pos_x;
        st_next.start_y     = smp.pos_y;
        st_next.start_time  = smp.time_ms;
      end
      st_next.recent_x = smp.pos_x;
      st_next.recent_y = smp.pos_y;
      if (long_fire) st_next.long_done = 1'b1;
    end else begin
      st_next.is_pressing = 1'b0;
      st_next.long_done   = 1'b0;
      if (is_dtap) begin
        st_next.tap_waiting = 1'b0;
      end else if (is_tap) begin
        st_next.tap_waiting = 1'b1;
        st_next.tap_time    = smp.time_ms;
        st_next.tap_x       = st.recent_x;
        st_next.tap_y       = st.recent_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

endmodule

/* design/touch_gesture_classifier_top.sv */
// Touch gesture classifier: one result word per sample, input register, result register.
// Each accepted sample (touching, pos_x, pos_y, time_ms) yields exactly one event_res
// word, in order: 0 none, 1 tap, 2 double tap, 3 long press, 4..7 swipe left, right,
// up, down. A sample is taken into an input register, classified against the gesture
// state by compare logic and written to the result register, so the block sustains
// one sample per clock unless out_stall holds a result; out_valid rises once the result
// register is written. in_stall rises only when both the input register and the result
// register are full and out_stall holds the result. Thresholds are set over the APB
// port (byte addresses 0x0, 0x4, 0x8, 0xC) and may only be changed while idle.
module touch_gesture_classifier_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          touching,
  input  logic [tgc_pkg::COORD_BITS-1:0] pos_x,
  input  logic [tgc_pkg::COORD_BITS-1:0] pos_y,
  input  logic [tgc_pkg::TIME_W-1:0]    time_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    event_res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tgc_pkg::ADDR_W-1:0]    paddr,
  input  logic [tgc_pkg::DATA_W-1:0]    pwdata,
  output logic [tgc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  tgc_pkg::cfg_t    cfg;
  tgc_pkg::sample_t in_q;
  logic             in_q_valid;
  logic             advance;
  logic             in_accept;
  tgc_pkg::ev_t     ev;

  assign advance   = in_q_valid && (!out_valid || !out_stall);
  assign in_stall  = in_q_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_accept) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_q.touching <= touching;
      in_q.pos_x    <= pos_x;
      in_q.pos_y    <= pos_y;
      in_q.time_ms  <= time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) event_res <= ev;
  end

  tgc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tgc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .smp  (in_q),
    .cfg  (cfg),
    .ev   (ev)
  );

endmodule

/* design/tgc_checker.sv */
// Port-level checks for the touch gesture classifier, bound to the top level.
`include "touch_gesture_classifier_top_defines.svh"

module tgc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] event_res,
  input logic       pready
);

  // input only backs up when a result word is held at the output
  `TGC_ASSERT_IMPL(a_stall_needs_full, in_stall, out_valid && out_stall, "in_stall without held result")

  // a held result word keeps its value
  `TGC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(event_res), "held result changed")

  // no word is left over from before reset
  `TGC_ASSERT_IMPL(a_reset_empty, $past(rst), !out_valid && !in_stall, "output busy right after reset")

  `TGC_ASSERT_IMPL(a_pready, 1'b1, pready, "pready dropped")

endmodule

bind touch_gesture_classifier_top tgc_checker u_tgc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .event_res (event_res),
  .pready    (pready)
);
